// ----- hw/rtl/dvr_pkg.sv -----
package dvr_pkg;

    localparam int NODES  = 16;
    localparam int NODE_W = $clog2(NODES);
    localparam int COST_W = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [COST_W-1:0] COST_MAX         = {COST_W{1'b1}};
    localparam logic [COST_W-1:0] ROUTE_RESET_COST = COST_W'(10000);
    localparam logic [NODE_W-1:0] SELF_RESET       = NODE_W'(1);
    localparam logic [COST_W-1:0] INFINITY_RESET   = COST_W'(10000);

    localparam logic REG_SELF_NODE     = 1'b0;
    localparam logic REG_INFINITY_COST = 1'b1;

    typedef enum logic [1:0] {
        OP_SET_LINK   = 2'd0,
        OP_INIT_ROUTE = 2'd1,
        OP_RELAX      = 2'd2,
        OP_READ_ROUTE = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   neighbor;
        logic [COST_W-1:0]   cost_value;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0]   route_cost;
        logic [NODE_W-1:0]   next_hop;
        logic                route_known;
        logic                improved;
    } out_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]   self_node;
        logic [COST_W-1:0]   infinity_cost;
    } cfg_t;

endpackage

// ----- hw/rtl/distance_vector_relax_unit.sv -----
// an accepted item goes to the input register, then the result register, where out_valid rises
// throughput: one item per cycle unless out_stall holds a result; each item reads and updates
// the register tables; a stalled result holds the input register, which then raises in_stall
// reset: async active low; routes cost 10000 with no next hop, no links,
// self_node 1, infinity_cost 10000
module distance_vector_relax_unit
    import dvr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic              in_vld_reg;
    logic              in_vld_next;
    in_item_t          in_item_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    out_item_t         out_item_reg;
    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              advance;
    logic              cfg_wr;
    out_item_t         result;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    assign in_vld_next  = in_stall ? in_vld_reg : in_valid;
    assign out_vld_next = advance ? 1'b1 : (out_vld_reg && out_stall);

    dvr_route_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_SELF_NODE:     cfg_next.self_node     = pwdata[NODE_W-1:0];
                REG_INFINITY_COST: cfg_next.infinity_cost = pwdata[COST_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SELF_NODE:     prdata = DATA_W'(cfg_reg.self_node);
            REG_INFINITY_COST: prdata = DATA_W'(cfg_reg.infinity_cost);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cfg_reg     <= '{self_node: SELF_RESET, infinity_cost: INFINITY_RESET};
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            cfg_reg     <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

`ifndef SYNTHESIS
    a_hop_zero_when_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.route_known || out_data.next_hop == '0))
        else $error("next hop set on unknown route");

    a_improved_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.improved |-> out_data.route_known)
        else $error("improved route without next hop");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_vld_reg)
        else $error("accepted item lost in input register");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("processed item missing from result register");
`endif

endmodule

// ----- hw/rtl/dvr_route_core.sv -----
module dvr_route_core
    import dvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [COST_W-1:0] link_cost_reg  [NODES];
    logic [NODES-1:0]  link_present_reg;
    logic [COST_W-1:0] route_cost_reg [NODES];
    logic [NODE_W-1:0] hop_reg        [NODES];
    logic [NODES-1:0]  hop_valid_reg;

    logic [COST_W:0]   sum_wide;
    logic [COST_W-1:0] sum_sat;
    logic              better;
    logic              link_wr;
    logic              route_wr;
    logic [COST_W-1:0] cost_next;
    logic [NODE_W-1:0] hop_next;
    logic              hop_valid_next;
    logic              improved;

    assign sum_wide = {1'b0, item.cost_value} + {1'b0, link_cost_reg[item.neighbor]};
    assign sum_sat  = sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];
    assign better   = link_present_reg[item.neighbor]
                      && (sum_sat < route_cost_reg[item.node]);

    always_comb
    begin
        link_wr        = 1'b0;
        route_wr       = 1'b0;
        improved       = 1'b0;
        cost_next      = route_cost_reg[item.node];
        hop_next       = hop_reg[item.node];
        hop_valid_next = hop_valid_reg[item.node];
        case (item.opcode)
            OP_SET_LINK:
            begin
                link_wr = 1'b1;
            end
            OP_INIT_ROUTE:
            begin
                route_wr = 1'b1;
                if (item.node == cfg.self_node)
                begin
                    cost_next      = '0;
                    hop_next       = item.node;
                    hop_valid_next = 1'b1;
                end
                else if (link_present_reg[item.node])
                begin
                    cost_next      = link_cost_reg[item.node];
                    hop_next       = item.node;
                    hop_valid_next = 1'b1;
                end
                else
                begin
                    cost_next      = cfg.infinity_cost;
                    hop_next       = '0;
                    hop_valid_next = 1'b0;
                end
            end
            OP_RELAX:
            begin
                if (better)
                begin
                    route_wr       = 1'b1;
                    improved       = 1'b1;
                    cost_next      = sum_sat;
                    hop_next       = item.neighbor;
                    hop_valid_next = 1'b1;
                end
            end
            default:
            begin
                route_wr = 1'b0;
            end
        endcase
    end

    assign result.route_cost  = cost_next;
    assign result.next_hop    = hop_valid_next ? hop_next : '0;
    assign result.route_known = hop_valid_next;
    assign result.improved    = improved;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_present_reg <= '0;
            hop_valid_reg    <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                route_cost_reg[i] <= ROUTE_RESET_COST;
            end
        end
        else if (fire)
        begin
            if (link_wr)
            begin
                link_present_reg[item.node] <= 1'b1;
            end
            if (route_wr)
            begin
                route_cost_reg[item.node] <= cost_next;
                hop_valid_reg[item.node]  <= hop_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && link_wr)
        begin
            link_cost_reg[item.node] <= item.cost_value;
        end
        if (fire && route_wr)
        begin
            hop_reg[item.node] <= hop_next;
        end
    end

endmodule
